// ===== sv/sbt_pkg.sv =====
`timescale 1ns / 1ps
package sbt_pkg;

	// fixed point format of coordinates
	localparam int COORD_FRAC_BITS = 12;

	// divider geometry: 18 quotient bits cover the clamp range [0, 2^17]
	localparam int QW      = 18;
	localparam int NW      = 52;          // |num| (36 bits) shifted up by 16
	localparam int DW      = 33;          // 2 * |motion|
	localparam int TW      = 19;          // signed Q0.16 time, +-2.0
	localparam int DIV_LAT = QW + 2;      // operand register, steps, fix-up

	// doubled lengths and numerators
	localparam int LW = 35;
	localparam int XW = 37;

	localparam logic [TW-1:0] TIME_CLAMP = TW'(131072);
	localparam logic [16:0]   ONE_Q16    = 17'd65536;

	// register indexes
	localparam logic [2:0] REG_HULL_MIN_X = 3'd0;
	localparam logic [2:0] REG_HULL_MIN_Y = 3'd1;
	localparam logic [2:0] REG_HULL_MIN_Z = 3'd2;
	localparam logic [2:0] REG_HULL_MAX_X = 3'd3;
	localparam logic [2:0] REG_HULL_MAX_Y = 3'd4;
	localparam logic [2:0] REG_HULL_MAX_Z = 3'd5;

	// register reset values
	localparam logic [20:0] HULL_MIN_X_RST = 21'h1F0000;   // -65536
	localparam logic [20:0] HULL_MIN_Y_RST = 21'h1DC000;   // -147456
	localparam logic [20:0] HULL_MIN_Z_RST = 21'h1F0000;   // -65536
	localparam logic [20:0] HULL_MAX_X_RST = 21'd65536;
	localparam logic [20:0] HULL_MAX_Y_RST = 21'd147456;
	localparam logic [20:0] HULL_MAX_Z_RST = 21'd65536;

	// entry face codes
	localparam logic [1:0] FACE_NONE = 2'd0;
	localparam logic [1:0] FACE_X    = 2'd1;
	localparam logic [1:0] FACE_Y    = 2'd2;
	localparam logic [1:0] FACE_Z    = 2'd3;

	typedef struct packed {
		logic signed [31:0] box_low_x;
		logic signed [31:0] box_low_y;
		logic signed [31:0] box_low_z;
		logic signed [31:0] box_high_x;
		logic signed [31:0] box_high_y;
		logic signed [31:0] box_high_z;
		logic signed [31:0] motion_x;
		logic signed [31:0] motion_y;
		logic signed [31:0] motion_z;
		logic [30:0]        move_length;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [16:0]        travel_fraction;
		logic [1:0]         hit_face_axis;
		logic               hit_face_negative;
		logic signed [31:0] travel_x;
		logic signed [31:0] travel_y;
		logic signed [31:0] travel_z;
	} rsp_t;

	// per item flags that ride alongside the dividers
	typedef struct packed {
		logic [2:0][31:0] motion;
		logic [2:0]       par;
		logic [2:0]       ovl_fail;
		logic [2:0]       d_neg;
		logic             short_move;
	} side_t;

endpackage

// ===== sv/sbt_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: floor((+-n) / d) as Q0.16, clamped to +-2.0
module sbt_div import sbt_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [NW-1:0]        dividend,
	input  logic [DW-1:0]        divisor,
	input  logic                 neg,
	output logic signed [TW-1:0] quot
);

	logic [NW-1:0] rem_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic [DW-1:0] den_s [0:QW];
	logic          neg_s [0:QW];
	logic          sat_s [0:QW];

	logic [NW-1:0] den_top;
	logic [TW-1:0] mag;

	// quotient beyond 18 bits saturates straight away
	assign den_top = {{(NW-DW-QW){1'b0}}, divisor, {QW{1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= dividend;
			quo_s[0] <= '0;
			den_s[0] <= divisor;
			neg_s[0] <= neg;
			sat_s[0] <= (dividend >= den_top);
		end
	end

	// one quotient bit per stage, msb first
	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int B = QW - 1 - k;
		logic [NW-1:0] sub_w;
		logic [NW:0]   diff;

		assign sub_w = {{(NW-DW){1'b0}}, den_s[k]} << B;
		assign diff  = {1'b0, rem_s[k]} - {1'b0, sub_w};

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				sat_s[k+1] <= sat_s[k];
				if (!diff[NW]) begin
					rem_s[k+1] <= diff[NW-1:0];
					quo_s[k+1] <= quo_s[k] | ({{(QW-1){1'b0}}, 1'b1} << B);
				end else begin
					rem_s[k+1] <= rem_s[k];
					quo_s[k+1] <= quo_s[k];
				end
			end
		end
	end

	// floor toward minus infinity, clamp, apply sign
	always_comb begin
		mag = {1'b0, quo_s[QW]} + TW'(neg_s[QW] & (|rem_s[QW]));
		if (sat_s[QW] || mag > TIME_CLAMP)
			mag = TIME_CLAMP;
	end

	always_ff @(posedge clk) begin
		if (en)
			quot <= neg_s[QW] ? -$signed(mag) : $signed(mag);
	end

endmodule

// ===== sv/swept_box_vs_box_trace_core.sv =====
`timescale 1ns / 1ps
// Swept box against box trace, slab method, fixed point with COORD_FRAC_BITS
// fraction bits.
// Request channel (req_valid, req_stall, req): one word per test, box corners
// relative to the hull start, the motion vector and the move length.
// Response channel (rsp_valid, rsp_stall, rsp): one word per request, in
// order: hit flag, Q0.16 travel fraction, entry face and displacement.
// Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): hull corners,
// to be written by the user only while the block is empty; the block does
// not enforce this. cfg_ready is always high and writes to unknown indexes
// are dropped. Throughput is one word per cycle while no response is held;
// the depth is set by the six restoring dividers (two per axis), which retire
// one quotient bit per stage over 18 stages.
// When rsp_stall holds a waiting response the whole pipeline freezes and
// req_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the default hull (+-16 x, +-36 y,
// +-16 z in Q.12).
module swept_box_vs_box_trace_core import sbt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [20:0] cfg_data
);

	// hull registers
	logic [20:0] hmin_q [3];
	logic [20:0] hmax_q [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hmin_q[0] <= HULL_MIN_X_RST;
			hmin_q[1] <= HULL_MIN_Y_RST;
			hmin_q[2] <= HULL_MIN_Z_RST;
			hmax_q[0] <= HULL_MAX_X_RST;
			hmax_q[1] <= HULL_MAX_Y_RST;
			hmax_q[2] <= HULL_MAX_Z_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HULL_MIN_X: hmin_q[0] <= cfg_data;
				REG_HULL_MIN_Y: hmin_q[1] <= cfg_data;
				REG_HULL_MIN_Z: hmin_q[2] <= cfg_data;
				REG_HULL_MAX_X: hmax_q[0] <= cfg_data;
				REG_HULL_MAX_Y: hmax_q[1] <= cfg_data;
				REG_HULL_MAX_Z: hmax_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: freeze only when a response is held
	logic en;
	logic rsp_valid_q;

	assign en        = !(rsp_valid_q && rsp_stall);
	assign req_stall = !en;
	assign rsp_valid = rsp_valid_q;

	// stage 1: request word
	logic v_s1;
	req_t req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (en && req_valid)
			req_s1 <= req;
	end

	// doubled centre offset and extent, parallel-axis test, short move
	logic signed [LW-1:0] d_c [3];
	logic signed [LW-1:0] e_c [3];
	logic [31:0]          mmag_c [3];
	logic [2:0]           par_c;
	logic                 short_c;
	logic signed [31:0]   lo_c [3];
	logic signed [31:0]   hi_c [3];
	logic signed [31:0]   m_c [3];
	logic signed [LW-1:0] hmn_c [3];
	logic signed [LW-1:0] hmx_c [3];
	logic [55:0]          pm_c [3];

	always_comb begin
		lo_c[0] = req_s1.box_low_x;
		lo_c[1] = req_s1.box_low_y;
		lo_c[2] = req_s1.box_low_z;
		hi_c[0] = req_s1.box_high_x;
		hi_c[1] = req_s1.box_high_y;
		hi_c[2] = req_s1.box_high_z;
		m_c[0]  = req_s1.motion_x;
		m_c[1]  = req_s1.motion_y;
		m_c[2]  = req_s1.motion_z;
		for (int a = 0; a < 3; a++) begin
			hmn_c[a]  = LW'($signed(hmin_q[a]));
			hmx_c[a]  = $signed({{(LW-21){1'b0}}, hmax_q[a]});
			d_c[a]    = (hmn_c[a] + hmx_c[a]) - (LW'(lo_c[a]) + LW'(hi_c[a]));
			e_c[a]    = (LW'(hi_c[a]) - LW'(lo_c[a])) + (hmx_c[a] - hmn_c[a]);
			mmag_c[a] = m_c[a][31] ? 32'(-m_c[a]) : 32'(m_c[a]);
			pm_c[a]   = 56'(mmag_c[a]) * 56'(24'd10000000);
			par_c[a]  = (pm_c[a] < 56'(req_s1.move_length)) || (m_c[a] == '0);
		end
		short_c = (45'(req_s1.move_length) * 45'(14'd10000))
		          < (45'd1 << COORD_FRAC_BITS);
	end

	// stage 2
	logic                 v_s2;
	logic signed [LW-1:0] d_s2 [3];
	logic signed [LW-1:0] e_s2 [3];
	logic [31:0]          mmag_s2 [3];
	logic [2:0][31:0]     m_s2;
	logic [2:0]           par_s2;
	logic                 short_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				d_s2[a]    <= d_c[a];
				e_s2[a]    <= e_c[a];
				mmag_s2[a] <= mmag_c[a];
				m_s2[a]    <= m_c[a];
			end
			par_s2   <= par_c;
			short_s2 <= short_c;
		end
	end

	// slab numerators, overlap test for parallel axes, divider operands
	logic signed [XW-1:0] n1_c [3];
	logic signed [XW-1:0] n2_c [3];
	logic [XW-2:0]        n1m_c [3];
	logic [XW-2:0]        n2m_c [3];
	logic [NW-1:0]        dvd1_c [3];
	logic [NW-1:0]        dvd2_c [3];
	logic [DW-1:0]        dvs_c [3];
	logic [2:0]           neg1_c;
	logic [2:0]           neg2_c;
	logic [LW-1:0]        dmag_c [3];
	side_t                side_c;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			n1_c[a]   = -XW'(e_s2[a]) - XW'(d_s2[a]);
			n2_c[a]   = XW'(e_s2[a]) - XW'(d_s2[a]);
			n1m_c[a]  = n1_c[a][XW-1] ? (XW-1)'(-n1_c[a]) : (XW-1)'(n1_c[a]);
			n2m_c[a]  = n2_c[a][XW-1] ? (XW-1)'(-n2_c[a]) : (XW-1)'(n2_c[a]);
			dvd1_c[a] = {n1m_c[a], 16'b0};
			dvd2_c[a] = {n2m_c[a], 16'b0};
			dvs_c[a]  = {mmag_s2[a], 1'b0};
			neg1_c[a] = n1_c[a][XW-1] ^ m_s2[a][31];
			neg2_c[a] = n2_c[a][XW-1] ^ m_s2[a][31];
			dmag_c[a] = d_s2[a][LW-1] ? LW'(-d_s2[a]) : LW'(d_s2[a]);
			side_c.ovl_fail[a] = $signed({2'b00, dmag_c[a]})
			                     > (XW'(e_s2[a]) + XW'(1 << (COORD_FRAC_BITS - 4)));
			side_c.d_neg[a]    = d_s2[a][LW-1];
		end
		side_c.motion     = m_s2;
		side_c.par        = par_s2;
		side_c.short_move = short_s2;
	end

	// six dividers, two per axis
	logic signed [TW-1:0] t1_w [3];
	logic signed [TW-1:0] t2_w [3];

	for (genvar a = 0; a < 3; a++) begin : g_axis
		sbt_div u_div_lo (
			.clk      (clk),
			.en       (en),
			.dividend (dvd1_c[a]),
			.divisor  (dvs_c[a]),
			.neg      (neg1_c[a]),
			.quot     (t1_w[a])
		);
		sbt_div u_div_hi (
			.clk      (clk),
			.en       (en),
			.dividend (dvd2_c[a]),
			.divisor  (dvs_c[a]),
			.neg      (neg2_c[a]),
			.quot     (t2_w[a])
		);
	end

	// side band delay matching the dividers
	logic  vd_q   [DIV_LAT];
	side_t side_sd [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++)
				vd_q[i] <= 1'b0;
		end else if (en) begin
			vd_q[0] <= v_s2;
			for (int i = 1; i < DIV_LAT; i++)
				vd_q[i] <= vd_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sd[0] <= side_c;
			for (int i = 1; i < DIV_LAT; i++)
				side_sd[i] <= side_sd[i-1];
		end
	end

	// combine the three slabs: latest entry, earliest exit
	localparam logic [1:0] FACE_OF [3] = '{FACE_X, FACE_Y, FACE_Z};

	side_t                sd_c;
	logic signed [TW-1:0] tlo_c;
	logic signed [TW-1:0] thi_c;
	logic signed [TW-1:0] entry_c;
	logic signed [TW-1:0] exit_c;
	logic [1:0]           face_c;
	logic                 fneg_c;
	logic                 hit_c;

	always_comb begin
		sd_c    = side_sd[DIV_LAT-1];
		entry_c = '0;
		exit_c  = $signed(TW'(ONE_Q16));
		face_c  = FACE_NONE;
		fneg_c  = 1'b0;
		hit_c   = !sd_c.short_move;
		tlo_c   = '0;
		thi_c   = '0;
		for (int a = 0; a < 3; a++) begin
			if (sd_c.par[a]) begin
				if (sd_c.ovl_fail[a])
					hit_c = 1'b0;
			end else begin
				tlo_c = (t1_w[a] > t2_w[a]) ? t2_w[a] : t1_w[a];
				thi_c = (t1_w[a] > t2_w[a]) ? t1_w[a] : t2_w[a];
				if (tlo_c > entry_c) begin
					entry_c = tlo_c;
					face_c  = FACE_OF[a];
					fneg_c  = sd_c.d_neg[a];
				end
				if (thi_c < exit_c)
					exit_c = thi_c;
				if (entry_c > exit_c)
					hit_c = 1'b0;
			end
		end
		if (entry_c >= $signed(TW'(ONE_Q16)))
			hit_c = 1'b0;
	end

	// stage 5: combined result
	logic             v_s5;
	logic             hit_s5;
	logic [16:0]      entry_s5;
	logic [1:0]       face_s5;
	logic             fneg_s5;
	logic [2:0][31:0] m_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= vd_q[DIV_LAT-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s5   <= hit_c;
			entry_s5 <= entry_c[16:0];
			face_s5  <= face_c;
			fneg_s5  <= fneg_c;
			m_s5     <= sd_c.motion;
		end
	end

	// stage 6: displacement products
	logic                 v_s6;
	logic                 hit_s6;
	logic [16:0]          entry_s6;
	logic [1:0]           face_s6;
	logic                 fneg_s6;
	logic [2:0][31:0]     m_s6;
	logic signed [49:0]   prod_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++)
				prod_s6[a] <= 50'($signed(m_s5[a])) * 50'($signed({1'b0, entry_s5}));
			hit_s6   <= hit_s5;
			entry_s6 <= entry_s5;
			face_s6  <= face_s5;
			fneg_s6  <= fneg_s5;
			m_s6     <= m_s5;
		end
	end

	// output register
	rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (en)
			rsp_valid_q <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q.hit <= hit_s6;
			if (hit_s6) begin
				rsp_q.travel_fraction   <= entry_s6;
				rsp_q.hit_face_axis     <= face_s6;
				rsp_q.hit_face_negative <= fneg_s6;
				rsp_q.travel_x          <= prod_s6[0][47:16];
				rsp_q.travel_y          <= prod_s6[1][47:16];
				rsp_q.travel_z          <= prod_s6[2][47:16];
			end else begin
				rsp_q.travel_fraction   <= ONE_Q16;
				rsp_q.hit_face_axis     <= FACE_NONE;
				rsp_q.hit_face_negative <= 1'b0;
				rsp_q.travel_x          <= m_s6[0];
				rsp_q.travel_y          <= m_s6[1];
				rsp_q.travel_z          <= m_s6[2];
			end
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== sv/sbt_checker.sv =====
`timescale 1ns / 1ps
// Port level checks for the trace core
module sbt_checker import sbt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input req_t        req,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input rsp_t        rsp,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [2:0]  cfg_index,
	input logic [20:0] cfg_data
);

	// held response word stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// request side only backs up behind a held response
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a held response");

	// a miss reports the whole move and no face
	a_miss_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit |-> rsp.travel_fraction == ONE_Q16
		&& rsp.hit_face_axis == FACE_NONE && !rsp.hit_face_negative)
		else $error("miss word malformed");

	// a hit ends inside the move
	a_hit_frac: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> rsp.travel_fraction < ONE_Q16)
		else $error("hit fraction out of range");

	// start overlap: no face means no travel
	a_start_ovl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit && rsp.hit_face_axis == FACE_NONE
		|-> rsp.travel_fraction == '0 && !rsp.hit_face_negative)
		else $error("faceless hit with non-zero fraction");

endmodule

bind swept_box_vs_box_trace_core sbt_checker u_sbt_checker (.*);
